@@ hdl/rgbamip_pkg.sv @@
`default_nettype none
package rgbamip_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_LEVELS = 11;

  localparam int CH_W    = 8;
  localparam int LEVEL_W = 4;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 11;
  localparam int PSUM_W  = 10;
  localparam int LINE_W  = 4 * PSUM_W;

  localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;

  // channel 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][CH_W-1:0] pixel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_READ
  } seq_state_t;

  typedef struct packed {
    logic we;
    logic re;
  } line_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/rgbamip_if.sv @@
`default_nettype none
interface rgbamip_in_if;
  import rgbamip_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic [CH_W-1:0] alpha_in;
  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rgbamip_out_if;
  import rgbamip_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] mip_level;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [CH_W-1:0]    red_out;
  logic [CH_W-1:0]    green_out;
  logic [CH_W-1:0]    blue_out;
  logic [CH_W-1:0]    alpha_out;
  logic               run_last;
  modport source (output valid, mip_level, pos_x, pos_y, red_out, green_out, blue_out,
                  alpha_out, run_last, input ready);
  modport sink (input valid, mip_level, pos_x, pos_y, red_out, green_out, blue_out,
                alpha_out, run_last, output ready);
endinterface
`default_nettype wire

@@ hdl/rgba_mip_chain_box_downsampler.sv @@
`default_nettype none
// level-0 beat is registered at the output from ST_EMIT after input acceptance, once the output is free
// each further level adds a line memory read (ST_READ) and then an emit (ST_EMIT)
// a new input is accepted only in ST_IDLE, after every level of the last pixel has emitted
// the output register lets the next input be accepted while a result waits
// reset (and any config write) returns all level counters and held pixels to zero
module rgba_mip_chain_box_downsampler #(
  parameter int MAX_WIDTH  = rgbamip_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LEVELS = rgbamip_pkg::DEF_MAX_LEVELS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rgbamip_in_if.sink                         in_bus,
  rgbamip_out_if.source                      out_bus,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_idx,
  input  wire logic [rgbamip_pkg::CFG_W-1:0] cfg_data
);
  import rgbamip_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int SW  = CW + 1;
  localparam int LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  function automatic logic [SW-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    if (t == 32'd0) begin
      t = 32'd1;
    end else if (t > 32'(MAX_WIDTH)) begin
      t = 32'(MAX_WIDTH);
    end
    return SW'(t);
  endfunction

  seq_state_t state_r, state_nxt;
  logic [SW-1:0]  width_r, height_r;
  logic [LVW-1:0] level_r, level_nxt;
  pixel_t         ch_r, ch_nxt;
  logic [3:0][CH_W:0] pair_r, pair_nxt, pair;
  logic [CW-1:0]  col_r [MAX_LEVELS];
  logic [CW-1:0]  row_r [MAX_LEVELS];
  pixel_t         hold_r [MAX_LEVELS];

  logic                out_valid_r;
  logic [LEVEL_W-1:0]  out_level_r;
  logic [POS_W-1:0]    out_x_r, out_y_r;
  pixel_t              out_pix_r;
  logic                out_last_r;

  logic [SW-1:0] lw, lh;
  logic [CW-1:0] x, y, col_nxt, row_nxt;
  logic          odd_x, odd_y, next_ok, descend, out_free, emit_go;
  line_ctrl_t    line_ctrl;
  logic [CW-1:0] line_addr;
  logic [LINE_W-1:0] line_wdata, line_rdata;
  logic [3:0][PSUM_W:0] vsum;

  always_comb begin
    lw       = width_r >> level_r;
    lh       = height_r >> level_r;
    x        = col_r[level_r];
    y        = row_r[level_r];
    odd_x    = x[0];
    odd_y    = y[0];
    next_ok  = (32'(level_r) + 32'd1 < 32'(MAX_LEVELS)) && (lw[SW-1:1] != '0) &&
               (lh[SW-1:1] != '0);
    descend  = odd_x && odd_y && next_ok;
    out_free = !out_valid_r || out_bus.ready;
    if (SW'(x) + SW'(1) >= lw) begin
      col_nxt = '0;
      row_nxt = (SW'(y) + SW'(1) >= lh) ? '0 : y + CW'(1);
    end else begin
      col_nxt = x + CW'(1);
      row_nxt = y;
    end
    for (int c = 0; c < 4; c++) begin
      pair[c]         = {1'b0, hold_r[level_r][c]} + {1'b0, ch_r[c]};
      line_wdata[c*PSUM_W +: PSUM_W] = PSUM_W'(pair[c]);
      vsum[c]         = {1'b0, line_rdata[c*PSUM_W +: PSUM_W]} + (PSUM_W+1)'(pair_r[c]);
    end
    // each level owns a region half the size of the previous one
    line_addr = CW'(32'(MAX_WIDTH) - (32'(MAX_WIDTH) >> level_r) + 32'(x >> 1));
  end

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    ch_nxt    = ch_r;
    pair_nxt  = pair_r;
    emit_go   = 1'b0;
    line_ctrl = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_bus.valid) begin
          state_nxt = ST_EMIT;
          level_nxt = '0;
          ch_nxt    = {in_bus.alpha_in, in_bus.blue_in, in_bus.green_in, in_bus.red_in};
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_go      = 1'b1;
          pair_nxt     = pair;
          line_ctrl.we = odd_x && !odd_y;
          if (descend) begin
            line_ctrl.re = 1'b1;
            state_nxt    = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
        level_nxt = level_r + LVW'(1);
        for (int c = 0; c < 4; c++) begin
          ch_nxt[c] = vsum[c][CH_W+1:2];
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_bus.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      level_r  <= '0;
      width_r  <= clamp_size(CFG_W'(1024));
      height_r <= clamp_size(CFG_W'(1024));
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      if (cfg_we && cfg_idx == CFG_IDX_WIDTH) begin
        width_r <= clamp_size(cfg_data);
      end
      if (cfg_we && cfg_idx == CFG_IDX_HEIGHT) begin
        height_r <= clamp_size(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    pair_r <= pair_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      for (int l = 0; l < MAX_LEVELS; l++) begin
        col_r[l]  <= '0;
        row_r[l]  <= '0;
        hold_r[l] <= '0;
      end
    end else if (emit_go) begin
      col_r[level_r] <= col_nxt;
      row_r[level_r] <= row_nxt;
      if (!odd_x) begin
        hold_r[level_r] <= ch_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_level_r <= LEVEL_W'(level_r);
      out_x_r     <= POS_W'(x);
      out_y_r     <= POS_W'(y);
      out_pix_r   <= ch_r;
      out_last_r  <= !descend;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.mip_level = out_level_r;
  assign out_bus.pos_x     = out_x_r;
  assign out_bus.pos_y     = out_y_r;
  assign out_bus.red_out   = out_pix_r[0];
  assign out_bus.green_out = out_pix_r[1];
  assign out_bus.blue_out  = out_pix_r[2];
  assign out_bus.alpha_out = out_pix_r[3];
  assign out_bus.run_last  = out_last_r;

  rgbamip_line_mem #(
    .DEPTH(MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .ctrl    (line_ctrl),
    .addr    (line_addr),
    .wdata   (line_wdata),
    .rdata_r (line_rdata)
  );

`ifndef SYNTHESIS
  a_read_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> $past(state_r) == ST_EMIT)
    else $error("line read without emit");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && !descend |=> state_r == ST_IDLE && out_bus.run_last)
    else $error("last beat did not end the item");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> 32'(level_r) < 32'(MAX_LEVELS))
    else $error("level out of range");

  a_no_emit_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.ready |-> !emit_go)
    else $error("emit over a stalled beat");
`endif

endmodule
`default_nettype wire

@@ hdl/rgbamip_line_mem.sv @@
`default_nettype none
module rgbamip_line_mem #(
  parameter int DEPTH = rgbamip_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                             clk,
  input  wire rgbamip_pkg::line_ctrl_t          ctrl,
  input  wire logic [$clog2(DEPTH)-1:0]         addr,
  input  wire logic [rgbamip_pkg::LINE_W-1:0]   wdata,
  output logic      [rgbamip_pkg::LINE_W-1:0]   rdata_r
);
  import rgbamip_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
module testbench;
  import rgbamip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLEV       = DEF_MAX_LEVELS;
  localparam int LINE_DEPTH = DEF_MAX_WIDTH;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    pixel_t             pix;
    logic               last;
  } mip_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = CFG_IDX_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  rgbamip_in_if  in_if ();
  rgbamip_out_if out_if ();

  rgba_mip_chain_box_downsampler u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_if),
    .out_bus  (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mip chain predictor state
  int unsigned img_w, img_h, num_levels;
  int unsigned lev_w [NLEV];
  int unsigned lev_h [NLEV];
  int unsigned lev_off [NLEV];
  int unsigned col_cnt [NLEV];
  int unsigned row_cnt [NLEV];
  pixel_t      left_pix [NLEV];
  logic [LINE_W-1:0] pair_line [LINE_DEPTH];

  mip_beat_t mip_expected [$];
  int err_cnt = 0;
  bit sender_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  int unsigned long_hold = 0;
  int unsigned stall_cycles = 0;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return v;
  endfunction

  function automatic void restart_chain();
    int unsigned w, h, m, off;
    w = clamp_dim(img_w);
    h = clamp_dim(img_h);
    m = (w > h) ? w : h;
    off = 0;
    num_levels = 0;
    while (m != 0) begin
      num_levels++;
      m >>= 1;
    end
    if (num_levels > NLEV) num_levels = NLEV;
    for (int l = 0; l < NLEV; l++) begin
      lev_w[l] = w >> l;
      lev_h[l] = h >> l;
      lev_off[l] = off;
      off += lev_w[l] / 2;
      left_pix[l] = '0;
      col_cnt[l] = 0;
      row_cnt[l] = 0;
    end
  endfunction

  function automatic void predict_chain(pixel_t p_in);
    pixel_t p;
    mip_beat_t b;
    int unsigned x, y, idx, l, n;
    logic [9:0] pair [4];
    bit more;
    p = p_in;
    l = 0;
    n = 0;
    while (l < num_levels && lev_w[l] != 0 && lev_h[l] != 0) begin
      x = col_cnt[l];
      y = row_cnt[l];
      b.level = l[LEVEL_W-1:0];
      b.x = x[POS_W-1:0];
      b.y = y[POS_W-1:0];
      b.pix = p;
      b.last = 1'b0;
      mip_expected.push_back(b);
      n++;
      more = 1'b0;
      if (x + 1 >= lev_w[l]) begin
        col_cnt[l] = 0;
        row_cnt[l] = (y + 1 >= lev_h[l]) ? 0 : y + 1;
      end else begin
        col_cnt[l] = x + 1;
      end
      if (x[0] == 1'b0) begin
        left_pix[l] = p;
      end else begin
        idx = lev_off[l] + x / 2;
        for (int c = 0; c < 4; c++) pair[c] = {2'b00, left_pix[l][c]} + {2'b00, p[c]};
        if (idx < LINE_DEPTH) begin
          if (y[0] == 1'b0) begin
            pair_line[idx] = {pair[3], pair[2], pair[1], pair[0]};
          end else begin
            for (int c = 0; c < 4; c++)
              p[c] = 8'((11'(pair_line[idx][10*c +: 10]) + 11'(pair[c])) >> 2);
            more = 1'b1;
          end
        end
      end
      if (!more) break;
      l++;
    end
    if (n > 0) mip_expected[mip_expected.size() - 1].last = 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (mip_expected.size() == 0) begin
        report("unexpected beat, level", 32'(out_if.mip_level), 32'd0);
      end else begin
        mip_beat_t e;
        e = mip_expected.pop_front();
        if (out_if.mip_level !== e.level)
          report("mip_level", 32'(out_if.mip_level), 32'(e.level));
        if (out_if.pos_x !== e.x) report("pos_x", 32'(out_if.pos_x), 32'(e.x));
        if (out_if.pos_y !== e.y) report("pos_y", 32'(out_if.pos_y), 32'(e.y));
        if (out_if.red_out !== e.pix[0])
          report("red_out", 32'(out_if.red_out), 32'(e.pix[0]));
        if (out_if.green_out !== e.pix[1])
          report("green_out", 32'(out_if.green_out), 32'(e.pix[1]));
        if (out_if.blue_out !== e.pix[2])
          report("blue_out", 32'(out_if.blue_out), 32'(e.pix[2]));
        if (out_if.alpha_out !== e.pix[3])
          report("alpha_out", 32'(out_if.alpha_out), 32'(e.pix[3]));
        if (out_if.run_last !== e.last)
          report("run_last", 32'(out_if.run_last), 32'(e.last));
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result sink with random and long holds
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold != 0) begin
        hold_left = long_hold;
        long_hold = 0;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_if.ready = 1'b0;
        hold_left = $urandom_range(1, 13) - 1;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic send_pixel(pixel_t p);
    if (sender_idle_en && $urandom_range(0, 5) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.red_in = p[0];
    in_if.green_in = p[1];
    in_if.blue_in = p[2];
    in_if.alpha_in = p[3];
    do @(posedge clk); while (!in_if.ready);
    predict_chain(p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (mip_expected.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_IDX_WIDTH) img_w = val;
    else img_h = val;
    restart_chain();
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(CFG_IDX_WIDTH, CFG_W'(w));
    write_reg(CFG_IDX_HEIGHT, CFG_W'(h));
  endtask

  function automatic pixel_t rand_pixel();
    return {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
  endfunction

  task automatic send_frame(int unsigned count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  task automatic test_pixel_extremes();
    send_pixel({8'h00, 8'hff, 8'h55, 8'haa});
    send_pixel({8'hff, 8'h00, 8'haa, 8'h55});
    set_size(4, 4);
    for (int i = 0; i < 16; i++)
      send_pixel((i % 3 == 0) ? {4{8'hff}} : (i % 3 == 1) ? {4{8'h00}} : {4{8'hfe}});
  endtask

  task automatic test_size_limits();
    set_size(0, 0);
    send_frame(2);
    set_size(2047, 1);
    send_frame(3);
    set_size(1, 1024);
    send_frame(3);
    set_size(1025, 2);
    send_frame(2);
  endtask

  task automatic test_frame_restart();
    set_size(2, 2);
    send_frame(8);
    send_frame(3);
    write_reg(CFG_IDX_HEIGHT, CFG_W'(2));
    send_frame(4);
  endtask

  task automatic test_random_frames();
    int unsigned sent, w, h, n;
    sent = 0;
    while (sent < 50) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      if ($urandom_range(0, 4) == 0) w = $urandom_range(13, 40);
      n = w * h;
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
      if (n > 40) n = 40;
      set_size(w, h);
      send_frame(n);
      sent += n;
    end
  endtask

  task automatic test_backpressure();
    set_size(8, 4);
    @(negedge clk);
    long_hold = 300;
    send_frame(32);
  endtask

  task automatic test_full_rate();
    sender_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    set_size(6, 6);
    send_frame(36);
    set_size(8, 4);
    send_frame(32);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.red_in = '0;
    in_if.green_in = '0;
    in_if.blue_in = '0;
    in_if.alpha_in = '0;
    img_w = 1024;
    img_h = 1024;
    restart_chain();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_pixel_extremes();
    test_size_limits();
    test_frame_restart();
    test_random_frames();
    test_backpressure();
    test_full_rate();
    drain();
    repeat (30) @(negedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ rgba_mip_chain_box_downsampler.f @@
hdl/rgbamip_pkg.sv
hdl/rgbamip_if.sv
hdl/rgbamip_line_mem.sv
hdl/rgba_mip_chain_box_downsampler.sv
sim/testbench.sv
